### src/sha512bh_pkg.sv
// ----------------------------------------------------------------------------
// SHA-512 block hash package
// Shared types, initial hash value, round constants and sigma functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sha512bh_pkg;

   localparam int unsigned WORDS_PER_BLOCK = 16;
   localparam int unsigned ROUNDS          = 80;
   localparam int unsigned DIGEST_WORDS    = 8;

   typedef logic [63:0] word_type;
   typedef logic [DIGEST_WORDS-1:0][63:0] digest_type;
   typedef logic [6:0] round_type;

   typedef struct packed {
      logic [63:0] message_word;
      logic        new_message;
      logic        final_block;
   } req_type;

   typedef struct packed {
      logic [63:0] digest_word;
      logic [2:0]  digest_index;
      logic        last_word;
   } rsp_type;

   typedef struct packed {
      logic load_word;
      logic step;
      logic expand;
   } ctrl_type;

   function automatic digest_type init_value();
      digest_type v;
      v[0] = 64'h6a09e667f3bcc908;
      v[1] = 64'hbb67ae8584caa73b;
      v[2] = 64'h3c6ef372fe94f82b;
      v[3] = 64'ha54ff53a5f1d36f1;
      v[4] = 64'h510e527fade682d1;
      v[5] = 64'h9b05688c2b3e6c1f;
      v[6] = 64'h1f83d9abfb41bd6b;
      v[7] = 64'h5be0cd19137e2179;
      return v;
   endfunction

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (64 - n));
   endfunction

   function automatic word_type small_s0(input word_type x);
      return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
   endfunction

   function automatic word_type small_s1(input word_type x);
      return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
   endfunction

   function automatic word_type big_s0(input word_type x);
      return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
   endfunction

   function automatic word_type big_s1(input word_type x);
      return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
   endfunction

   function automatic word_type round_k(input round_type r);
      word_type k;
      case (r)
         7'd0:  k = 64'h428a2f98d728ae22;
         7'd1:  k = 64'h7137449123ef65cd;
         7'd2:  k = 64'hb5c0fbcfec4d3b2f;
         7'd3:  k = 64'he9b5dba58189dbbc;
         7'd4:  k = 64'h3956c25bf348b538;
         7'd5:  k = 64'h59f111f1b605d019;
         7'd6:  k = 64'h923f82a4af194f9b;
         7'd7:  k = 64'hab1c5ed5da6d8118;
         7'd8:  k = 64'hd807aa98a3030242;
         7'd9:  k = 64'h12835b0145706fbe;
         7'd10: k = 64'h243185be4ee4b28c;
         7'd11: k = 64'h550c7dc3d5ffb4e2;
         7'd12: k = 64'h72be5d74f27b896f;
         7'd13: k = 64'h80deb1fe3b1696b1;
         7'd14: k = 64'h9bdc06a725c71235;
         7'd15: k = 64'hc19bf174cf692694;
         7'd16: k = 64'he49b69c19ef14ad2;
         7'd17: k = 64'hefbe4786384f25e3;
         7'd18: k = 64'h0fc19dc68b8cd5b5;
         7'd19: k = 64'h240ca1cc77ac9c65;
         7'd20: k = 64'h2de92c6f592b0275;
         7'd21: k = 64'h4a7484aa6ea6e483;
         7'd22: k = 64'h5cb0a9dcbd41fbd4;
         7'd23: k = 64'h76f988da831153b5;
         7'd24: k = 64'h983e5152ee66dfab;
         7'd25: k = 64'ha831c66d2db43210;
         7'd26: k = 64'hb00327c898fb213f;
         7'd27: k = 64'hbf597fc7beef0ee4;
         7'd28: k = 64'hc6e00bf33da88fc2;
         7'd29: k = 64'hd5a79147930aa725;
         7'd30: k = 64'h06ca6351e003826f;
         7'd31: k = 64'h142929670a0e6e70;
         7'd32: k = 64'h27b70a8546d22ffc;
         7'd33: k = 64'h2e1b21385c26c926;
         7'd34: k = 64'h4d2c6dfc5ac42aed;
         7'd35: k = 64'h53380d139d95b3df;
         7'd36: k = 64'h650a73548baf63de;
         7'd37: k = 64'h766a0abb3c77b2a8;
         7'd38: k = 64'h81c2c92e47edaee6;
         7'd39: k = 64'h92722c851482353b;
         7'd40: k = 64'ha2bfe8a14cf10364;
         7'd41: k = 64'ha81a664bbc423001;
         7'd42: k = 64'hc24b8b70d0f89791;
         7'd43: k = 64'hc76c51a30654be30;
         7'd44: k = 64'hd192e819d6ef5218;
         7'd45: k = 64'hd69906245565a910;
         7'd46: k = 64'hf40e35855771202a;
         7'd47: k = 64'h106aa07032bbd1b8;
         7'd48: k = 64'h19a4c116b8d2d0c8;
         7'd49: k = 64'h1e376c085141ab53;
         7'd50: k = 64'h2748774cdf8eeb99;
         7'd51: k = 64'h34b0bcb5e19b48a8;
         7'd52: k = 64'h391c0cb3c5c95a63;
         7'd53: k = 64'h4ed8aa4ae3418acb;
         7'd54: k = 64'h5b9cca4f7763e373;
         7'd55: k = 64'h682e6ff3d6b2b8a3;
         7'd56: k = 64'h748f82ee5defb2fc;
         7'd57: k = 64'h78a5636f43172f60;
         7'd58: k = 64'h84c87814a1f0ab72;
         7'd59: k = 64'h8cc702081a6439ec;
         7'd60: k = 64'h90befffa23631e28;
         7'd61: k = 64'ha4506cebde82bde9;
         7'd62: k = 64'hbef9a3f7b2c67915;
         7'd63: k = 64'hc67178f2e372532b;
         7'd64: k = 64'hca273eceea26619c;
         7'd65: k = 64'hd186b8c721c0c207;
         7'd66: k = 64'heada7dd6cde0eb1e;
         7'd67: k = 64'hf57d4f7fee6ed178;
         7'd68: k = 64'h06f067aa72176fba;
         7'd69: k = 64'h0a637dc5a2c898a6;
         7'd70: k = 64'h113f9804bef90dae;
         7'd71: k = 64'h1b710b35131c471b;
         7'd72: k = 64'h28db77f523047d84;
         7'd73: k = 64'h32caab7b40c72493;
         7'd74: k = 64'h3c9ebe0a15c9bebc;
         7'd75: k = 64'h431d67c49c100d4c;
         7'd76: k = 64'h4cc5d4becb3e42b6;
         7'd77: k = 64'h597f299cfc657e2a;
         7'd78: k = 64'h5fcb6fab3ad6faec;
         7'd79: k = 64'h6c44198c4a475817;
         default: k = '0;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

### src/sha512bh_sched.sv
// ----------------------------------------------------------------------------
// SHA-512 message schedule
// Sixteen-word window: takes message words in, then rotates or expands one
// schedule word per round.
// ----------------------------------------------------------------------------
`default_nettype none

module sha512bh_sched (
   input  wire logic                  clock,
   input  wire sha512bh_pkg::ctrl_type ctrl,
   input  wire sha512bh_pkg::word_type word_in,
   output sha512bh_pkg::word_type      sched_word
);
   import sha512bh_pkg::*;

   word_type window_ff [WORDS_PER_BLOCK];
   word_type expanded;

   assign expanded = small_s1(window_ff[14]) + window_ff[9]
                   + small_s0(window_ff[1]) + window_ff[0];
   assign sched_word = ctrl.expand ? expanded : window_ff[0];

   always_ff @(posedge clock) begin
      if (ctrl.load_word || ctrl.step) begin
         for (int i = 0; i < WORDS_PER_BLOCK - 1; i++) begin
            window_ff[i] <= window_ff[i+1];
         end
         window_ff[WORDS_PER_BLOCK-1] <= ctrl.load_word ? word_in : sched_word;
      end
   end

endmodule

`default_nettype wire

### src/sha512bh_round.sv
// ----------------------------------------------------------------------------
// SHA-512 round unit
// Working variables a..h and the shared round datapath, one round a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sha512bh_round (
   input  wire logic                    clock,
   input  wire logic                    start,
   input  wire sha512bh_pkg::ctrl_type   ctrl,
   input  wire sha512bh_pkg::round_type  round,
   input  wire sha512bh_pkg::word_type   sched_word,
   input  wire sha512bh_pkg::digest_type chain,
   output sha512bh_pkg::digest_type      vars
);
   import sha512bh_pkg::*;

   digest_type vars_ff;
   word_type   t1;
   word_type   t2;
   word_type   ch;
   word_type   maj;

   assign vars = vars_ff;
   assign ch   = (vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]);
   assign maj  = (vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
               ^ (vars_ff[1] & vars_ff[2]);
   assign t1   = vars_ff[7] + big_s1(vars_ff[4]) + ch + round_k(round) + sched_word;
   assign t2   = big_s0(vars_ff[0]) + maj;

   always_ff @(posedge clock) begin
      if (start) begin
         vars_ff <= chain;
      end else if (ctrl.step) begin
         vars_ff[7] <= vars_ff[6];
         vars_ff[6] <= vars_ff[5];
         vars_ff[5] <= vars_ff[4];
         vars_ff[4] <= vars_ff[3] + t1;
         vars_ff[3] <= vars_ff[2];
         vars_ff[2] <= vars_ff[1];
         vars_ff[1] <= vars_ff[0];
         vars_ff[0] <= t1 + t2;
      end
   end

endmodule

`default_nettype wire

### src/sha512bh_emit.sv
// ----------------------------------------------------------------------------
// SHA-512 digest emitter
// Holds a finished digest and shifts it out one word per response.
// ----------------------------------------------------------------------------
`default_nettype none

module sha512bh_emit (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  wire sha512bh_pkg::digest_type digest,
   output logic                          busy,
   output logic                          rsp_valid,
   input  wire logic                    rsp_ready,
   output sha512bh_pkg::rsp_type         rsp_data
);
   import sha512bh_pkg::*;

   digest_type buf_ff;
   logic [2:0] index_ff;
   logic       busy_ff;

   assign busy                  = busy_ff;
   assign rsp_valid             = busy_ff;
   assign rsp_data.digest_word  = buf_ff[0];
   assign rsp_data.digest_index = index_ff;
   assign rsp_data.last_word    = (index_ff == 3'(DIGEST_WORDS - 1));

   always_ff @(posedge clock) begin
      if (load) begin
         buf_ff <= digest;
      end else if (busy_ff && rsp_ready) begin
         buf_ff <= {64'h0, buf_ff[DIGEST_WORDS-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         index_ff <= '0;
      end else if (load) begin
         busy_ff  <= 1'b1;
         index_ff <= '0;
      end else if (busy_ff && rsp_ready) begin
         if (rsp_data.last_word) begin
            busy_ff <= 1'b0;
         end
         index_ff <= index_ff + 3'd1;
      end
   end

endmodule

`default_nettype wire

### src/sha512_block_hash.sv
// ----------------------------------------------------------------------------
// SHA-512 block hash
// Compression core for padded messages given as 64-bit big-endian words.
// ----------------------------------------------------------------------------
// Words are taken one a cycle while the core is idle. The sixteenth word of
// a block starts the compression: the round unit runs 80 rounds at one a
// cycle, then the ADD state adds the result into the chaining value, so
// request ready stays low from that word until that add is done.
// On a final block the digest is copied into an output buffer and sent as
// eight responses while new requests are taken; the chaining add waits only
// if the previous digest has not yet been fully taken.
`default_nettype none

module sha512_block_hash (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire sha512bh_pkg::req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output sha512bh_pkg::rsp_type     rsp_data
);
   import sha512bh_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      ROUND,
      ADD
   } state_type;

   state_type  state_ff;
   state_type  state_in;
   logic [3:0] count_ff;
   logic [3:0] count_in;
   logic [3:0] count_eff;
   round_type  round_ff;
   round_type  round_in;
   logic       final_ff;
   logic       final_in;
   digest_type chain_ff;
   digest_type chain_in;
   digest_type sum;
   digest_type vars;
   ctrl_type   ctrl;
   word_type   sched_word;
   logic       accept;
   logic       start;
   logic       add_done;
   logic       emit_load;
   logic       emit_busy;

   assign req_ready = (state_ff == IDLE);
   assign accept    = req_valid && req_ready;
   assign count_eff = req_data.new_message ? 4'd0 : count_ff;
   assign start     = accept && (count_eff == 4'(WORDS_PER_BLOCK - 1));
   assign add_done  = (state_ff == ADD) && !(final_ff && emit_busy);
   assign emit_load = add_done && final_ff;

   assign ctrl.load_word = accept;
   assign ctrl.step      = (state_ff == ROUND);
   assign ctrl.expand    = (round_ff >= 7'(WORDS_PER_BLOCK));

   always_comb begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
         sum[i] = chain_ff[i] + vars[i];
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      round_in = round_ff;
      final_in = final_ff;
      chain_in = chain_ff;
      case (state_ff)
         IDLE: begin
            if (accept) begin
               if (req_data.new_message) begin
                  chain_in = init_value();
               end
               if (start) begin
                  count_in = '0;
                  round_in = '0;
                  final_in = req_data.final_block;
                  state_in = ROUND;
               end else begin
                  count_in = count_eff + 4'd1;
               end
            end
         end
         ROUND: begin
            round_in = round_ff + 7'd1;
            if (round_ff == 7'(ROUNDS - 1)) begin
               state_in = ADD;
            end
         end
         ADD: begin
            if (add_done) begin
               chain_in = sum;
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         count_ff <= '0;
         round_ff <= '0;
         final_ff <= 1'b0;
         chain_ff <= init_value();
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         round_ff <= round_in;
         final_ff <= final_in;
         chain_ff <= chain_in;
      end
   end

   sha512bh_sched u_sched (
      .clock      (clock),
      .ctrl       (ctrl),
      .word_in    (req_data.message_word),
      .sched_word (sched_word)
   );

   sha512bh_round u_round (
      .clock      (clock),
      .start      (start),
      .ctrl       (ctrl),
      .round      (round_ff),
      .sched_word (sched_word),
      .chain      (chain_ff),
      .vars       (vars)
   );

   sha512bh_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (emit_load),
      .digest    (sum),
      .busy      (emit_busy),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### verif/digest_checker.sv
// ----------------------------------------------------------------------------
// SHA-512 digest checker
// Watches the request and response channels of the block hash core, keeps its
// own SHA-512 compression of every accepted request and compares each
// accepted digest word with the oldest one still due.
// ----------------------------------------------------------------------------
`default_nettype none

module digest_checker (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire sha512bh_pkg::req_type req_data,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire sha512bh_pkg::rsp_type rsp_data,
   output int                         error_total,
   output int                         words_due
);

   import sha512bh_pkg::*;

   logic [63:0] iv_words [0:7] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   logic [63:0] round_const [0:79] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   logic [63:0] hash_state [0:7];
   logic [63:0] block_words [0:15];
   logic [3:0]  word_pos;
   rsp_type     digest_due [$];
   int          errors;

   function automatic logic [63:0] rot_right(input logic [63:0] x, input int unsigned n);
      logic [127:0] both;
      both = {x, x} >> n;
      return both[63:0];
   endfunction

   function automatic logic [63:0] msg_sigma0(input logic [63:0] x);
      return rot_right(x, 1) ^ rot_right(x, 8) ^ (x >> 7);
   endfunction

   function automatic logic [63:0] msg_sigma1(input logic [63:0] x);
      return rot_right(x, 19) ^ rot_right(x, 61) ^ (x >> 6);
   endfunction

   function automatic logic [63:0] sum_sigma0(input logic [63:0] x);
      return rot_right(x, 28) ^ rot_right(x, 34) ^ rot_right(x, 39);
   endfunction

   function automatic logic [63:0] sum_sigma1(input logic [63:0] x);
      return rot_right(x, 14) ^ rot_right(x, 18) ^ rot_right(x, 41);
   endfunction

   function automatic void compress_block();
      logic [63:0] w [0:15];
      logic [63:0] v [0:7];
      logic [63:0] wr, t1, t2;
      int          r, i;
      w = block_words;
      v = hash_state;
      for (r = 0; r < 80; r++) begin
         if (r < 16) begin
            wr = w[r];
         end else begin
            wr = msg_sigma1(w[(r - 2) % 16]) + w[(r - 7) % 16]
               + msg_sigma0(w[(r - 15) % 16]) + w[r % 16];
            w[r % 16] = wr;
         end
         t1 = v[7] + sum_sigma1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
            + round_const[r] + wr;
         t2 = sum_sigma0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
   endfunction

   function automatic void absorb_word(input req_type r);
      rsp_type d;
      int      i;
      if (r.new_message) begin
         hash_state = iv_words;
         word_pos = '0;
      end
      block_words[word_pos] = r.message_word;
      if (word_pos != 4'd15) begin
         word_pos = word_pos + 4'd1;
         return;
      end
      word_pos = '0;
      compress_block();
      if (r.final_block) begin
         for (i = 0; i < 8; i++) begin
            d.digest_word  = hash_state[i];
            d.digest_index = 3'(i);
            d.last_word    = (i == 7);
            digest_due.push_back(d);
         end
      end
   endfunction

   function automatic void check_digest_word(input rsp_type got);
      rsp_type want;
      if (digest_due.size() == 0) begin
         $error("digest word with none due: index %0d word %h", got.digest_index,
                got.digest_word);
         errors++;
         return;
      end
      want = digest_due.pop_front();
      if (got.digest_word !== want.digest_word) begin
         $error("digest_word: expected %h, actual %h", want.digest_word, got.digest_word);
         errors++;
      end
      if (got.digest_index !== want.digest_index) begin
         $error("digest_index: expected %0d, actual %0d", want.digest_index, got.digest_index);
         errors++;
      end
      if (got.last_word !== want.last_word) begin
         $error("last_word: expected %0b, actual %0b", want.last_word, got.last_word);
         errors++;
      end
   endfunction

   initial errors = 0;

   always @(posedge clock) begin
      if (reset) begin
         hash_state = iv_words;
         word_pos = '0;
         digest_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_digest_word(rsp_data);
         if (req_valid && req_ready) absorb_word(req_data);
      end
      words_due   <= digest_due.size();
      error_total <= errors;
   end

endmodule

`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// SHA-512 block hash testbench
// Feeds message words to the core with random gaps and back-pressure,
// including a long response hold-off, and leaves checking to the digest
// checker; gives the verdict once all due digest words are in, or by watchdog.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

   import sha512bh_pkg::*;

   localparam int ITEM_TARGET    = 380;
   localparam int HOLD_CYCLES    = 800;
   localparam int DRAIN_CYCLES   = 200;
   localparam int WATCHDOG_LIMIT = 5000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic    calm      = 1'b0;
   logic    hold_ask  = 1'b0;
   int      items_sent = 0;
   int      idle_cycles = 0;
   int      error_total;
   int      words_due;

   always #2 clock = ~clock;

   sha512_block_hash i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   digest_checker i_digest_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .error_total (error_total),
      .words_due   (words_due)
   );

   function automatic logic [63:0] random_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic push_word(input req_type r);
      while (!calm && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // cut_words non-zero: stop the last block short after that many words
   task automatic send_message(input int blocks, input bit fresh, input int cut_words);
      req_type r;
      int      b, j, n;
      for (b = 0; b < blocks; b++) begin
         n = (b == blocks - 1 && cut_words != 0) ? cut_words : 16;
         for (j = 0; j < n; j++) begin
            r.message_word = random_word();
            r.new_message  = fresh && b == 0 && j == 0;
            if (j == 15) r.final_block = (b == blocks - 1);
            else r.final_block = 1'($urandom_range(1));
            push_word(r);
         end
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
   endtask

   initial begin : sink
      bit held;
      int n;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_ask && !held) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            for (n = 0; n < HOLD_CYCLES; n++) @(posedge clock);
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 21);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("sha512_block_hash: mismatch");
         $finish;
      end
   end

   initial begin : source
      req_type r;
      int      j, pick;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // partial block from reset, dropped by the next new message
      for (j = 0; j < 3; j++) begin
         r.message_word = '1;
         r.new_message  = 1'b0;
         r.final_block  = 1'b1;
         push_word(r);
      end
      for (j = 0; j < 16; j++) begin
         case (j)
            0: r.message_word = '1;
            1: r.message_word = '0;
            2: r.message_word = 64'h8000_0000_0000_0000;
            3: r.message_word = 64'h1;
            4: r.message_word = 64'h5555_5555_5555_5555;
            5: r.message_word = 64'haaaa_aaaa_aaaa_aaaa;
            default: r.message_word = {$urandom, $urandom};
         endcase
         r.new_message = (j == 0);
         r.final_block = (j == 7 || j == 15);
         push_word(r);
      end

      // hold the response side off so that digests back up into the request side
      hold_ask <= 1'b1;
      repeat (3) send_message(1, 1'b1, 0);
      wait_drained();

      while (items_sent < ITEM_TARGET) begin
         calm <= (items_sent >= 160 && items_sent < 260);
         pick = $urandom_range(99);
         if (pick < 12) send_message(1, 1'b1, $urandom_range(15, 1));
         else if (pick < 22) send_message($urandom_range(2, 1), 1'b0, 0);
         else send_message(($urandom_range(9) < 7) ? 1 : $urandom_range(3, 2), 1'b1, 0);
      end
      req_valid <= 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_total == 0 && words_due == 0) begin
         $display("sha512_block_hash: match");
      end else begin
         $display("sha512_block_hash: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire

### files.f
src/sha512bh_pkg.sv
src/sha512bh_sched.sv
src/sha512bh_round.sv
src/sha512bh_emit.sv
src/sha512_block_hash.sv
verif/digest_checker.sv
verif/testbench.sv
